FILE: rtl/core/assert_macros.svh
// assertion macros shared by the queue and back end modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define MTCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define MTCR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/mtcr_pkg.sv
// package with constants, codes and types of the text cell row renderer
package mtcr_pkg;

  localparam int CELL_WIDTH     = 9;
  localparam int CELL_HEIGHT    = 14;
  localparam int UNDERLINE_LINE = 12;

  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int LINE_W   = 4;
  localparam int ATTR_W   = 8;
  localparam int GLYPH_W  = 9;
  localparam int X_W      = 10;
  localparam int Y_W      = 9;
  localparam int COLOUR_W = 24;

  localparam int K_W = $clog2(CELL_WIDTH);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_NORMAL = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BRIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BACK   = 2'd2;

  localparam logic [COLOUR_W-1:0] NORMAL_RESET = 24'hAAAAAA;
  localparam logic [COLOUR_W-1:0] BRIGHT_RESET = 24'hFFFFFF;
  localparam logic [COLOUR_W-1:0] BACK_RESET   = 24'h000000;

  localparam logic [2:0] ATTR_BLACK = 3'd0;
  localparam logic [2:0] ATTR_ULINE = 3'd1;
  localparam logic [2:0] ATTR_WHITE = 3'd7;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_INVERSE,
    MODE_INVISIBLE,
    MODE_UNDERLINE
  } mode_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] normal;
    logic [COLOUR_W-1:0] bright;
    logic [COLOUR_W-1:0] back;
  } colour_set_t;

  typedef struct packed {
    logic [X_W-1:0]        x0;
    logic [Y_W-1:0]        y;
    logic [COLOUR_W-1:0]   fg;
    logic [COLOUR_W-1:0]   bg;
    logic                  solid;
    logic [CELL_WIDTH-1:0] glyph;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

FILE: rtl/core/mtcr_in_if.sv
// input channel interface carrying one cell line item
interface mtcr_in_if;
  import mtcr_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cell_column;
  logic [ROW_W-1:0]  cell_row;
  logic [LINE_W-1:0] cell_line;
  logic [ATTR_W-1:0] attribute;
  logic [GLYPH_W-1:0] glyph_bits;

  modport source (
    output valid, cell_column, cell_row, cell_line, attribute, glyph_bits,
    input  ready
  );
  modport sink (
    input  valid, cell_column, cell_row, cell_line, attribute, glyph_bits,
    output ready
  );
endinterface

FILE: rtl/core/mtcr_out_if.sv
// result channel interface carrying one pixel item
interface mtcr_out_if;
  import mtcr_pkg::*;

  logic                valid;
  logic                ready;
  logic [X_W-1:0]      pixel_x;
  logic [Y_W-1:0]      pixel_y;
  logic [COLOUR_W-1:0] pixel_colour;
  logic                last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_colour, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_colour, last_pixel,
    output ready
  );
endinterface

FILE: rtl/core/mtcr_cfg_regs.sv
// apb colour registers
module mtcr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mtcr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mtcr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mtcr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output mtcr_pkg::colour_set_t           colours
);
  import mtcr_pkg::*;

  colour_set_t            col_r, col_nxt;
  logic [REG_IDX_W-1:0]   idx;
  logic                   wr_en;

  always_comb begin
    idx     = paddr[APB_ADDR_W-1:2];
    wr_en   = psel && penable && pwrite;
    col_nxt = col_r;
    prdata  = '0;
    unique case (idx)
      REG_NORMAL: begin
        prdata = APB_DATA_W'(col_r.normal);
        if (wr_en) col_nxt.normal = pwdata[COLOUR_W-1:0];
      end
      REG_BRIGHT: begin
        prdata = APB_DATA_W'(col_r.bright);
        if (wr_en) col_nxt.bright = pwdata[COLOUR_W-1:0];
      end
      REG_BACK: begin
        prdata = APB_DATA_W'(col_r.back);
        if (wr_en) col_nxt.back = pwdata[COLOUR_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r.normal <= NORMAL_RESET;
      col_r.bright <= BRIGHT_RESET;
      col_r.back   <= BACK_RESET;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign pready  = 1'b1;
  assign colours = col_r;

endmodule

FILE: rtl/core/mtcr_front.sv
// front end: accepts cell line items and resolves mode, colours and coordinates
module mtcr_front (
  mtcr_in_if.sink                   in_ch,
  input  mtcr_pkg::colour_set_t     colours,
  input  mtcr_pkg::q_stat_t         q_stat,
  output logic                      push,
  output mtcr_pkg::q_entry_t        entry
);
  import mtcr_pkg::*;

  mode_t        mode;
  logic [2:0]   bg_attr;
  logic [2:0]   fg_attr;
  logic [COLOUR_W-1:0] lit_fg;

  always_comb begin
    bg_attr = in_ch.attribute[6:4];
    fg_attr = in_ch.attribute[2:0];
    priority if (bg_attr == ATTR_WHITE && fg_attr == ATTR_BLACK) begin
      mode = MODE_INVERSE;
    end else if (bg_attr == ATTR_BLACK && fg_attr == ATTR_BLACK) begin
      mode = MODE_INVISIBLE;
    end else if (bg_attr == ATTR_BLACK && fg_attr == ATTR_ULINE) begin
      mode = MODE_UNDERLINE;
    end else begin
      mode = MODE_NORMAL;
    end

    lit_fg = in_ch.attribute[3] ? colours.bright : colours.normal;
    entry.solid = 1'b0;
    unique case (mode)
      MODE_INVERSE: begin
        entry.fg = colours.back;
        entry.bg = colours.normal;
      end
      MODE_INVISIBLE: begin
        entry.fg = colours.back;
        entry.bg = colours.back;
      end
      MODE_UNDERLINE: begin
        entry.fg    = lit_fg;
        entry.bg    = colours.back;
        entry.solid = (in_ch.cell_line == LINE_W'(UNDERLINE_LINE));
      end
      default: begin
        entry.fg = lit_fg;
        entry.bg = colours.back;
      end
    endcase

    entry.x0    = X_W'(X_W'(in_ch.cell_column) * X_W'(CELL_WIDTH));
    entry.y     = Y_W'(Y_W'(in_ch.cell_row) * Y_W'(CELL_HEIGHT) + Y_W'(in_ch.cell_line));
    entry.glyph = CELL_WIDTH'(in_ch.glyph_bits);
  end

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

endmodule

FILE: rtl/core/mtcr_queue.sv
// short queue between the front end and the pixel sequencer
module mtcr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mtcr_pkg::q_entry_t  wr_entry,
  input  logic                pop,
  output mtcr_pkg::q_entry_t  rd_entry,
  output mtcr_pkg::q_stat_t   q_stat
);
  import mtcr_pkg::*;
  `include "assert_macros.svh"

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  assign rd_entry     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.valid = (cnt_r != '0);

  `MTCR_ASSERT(a_q_no_overfill, cnt_r <= QCNT_W'(QDEPTH), "queue count above depth")
  `MTCR_ASSERT(a_q_no_underrun, pop |-> cnt_r != '0, "pop from empty queue")

endmodule

FILE: rtl/core/mtcr_back.sv
// back end: steps through the pixels of one cell line into the output register
module mtcr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mtcr_pkg::q_entry_t  rd_entry,
  input  mtcr_pkg::q_stat_t   q_stat,
  output logic                pop,
  mtcr_out_if.source          out_ch
);
  import mtcr_pkg::*;
  `include "assert_macros.svh"

  logic                  busy_r, busy_nxt;
  logic [K_W-1:0]        k_r, k_nxt;
  logic [X_W-1:0]        x_r, x_nxt;
  logic [Y_W-1:0]        y_r, y_nxt;
  logic [COLOUR_W-1:0]   fg_r, fg_nxt;
  logic [COLOUR_W-1:0]   bg_r, bg_nxt;
  logic                  solid_r, solid_nxt;
  logic [CELL_WIDTH-1:0] glyph_r, glyph_nxt;

  logic                  ov_r, ov_nxt;
  logic [X_W-1:0]        px_r, px_nxt;
  logic [Y_W-1:0]        py_r, py_nxt;
  logic [COLOUR_W-1:0]   pc_r, pc_nxt;
  logic                  pl_r, pl_nxt;

  logic                  advance;
  logic                  last_k;

  always_comb begin
    advance = busy_r && (!ov_r || out_ch.ready);
    last_k  = (k_r == K_W'(CELL_WIDTH - 1));
    pop     = q_stat.valid && (!busy_r || (advance && last_k));

    busy_nxt  = busy_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    fg_nxt    = fg_r;
    bg_nxt    = bg_r;
    solid_nxt = solid_r;
    glyph_nxt = glyph_r;

    if (pop) begin
      busy_nxt  = 1'b1;
      k_nxt     = '0;
      x_nxt     = rd_entry.x0;
      y_nxt     = rd_entry.y;
      fg_nxt    = rd_entry.fg;
      bg_nxt    = rd_entry.bg;
      solid_nxt = rd_entry.solid;
      glyph_nxt = rd_entry.glyph;
    end else if (advance && last_k) begin
      busy_nxt = 1'b0;
    end else if (advance) begin
      k_nxt     = k_r + 1'b1;
      x_nxt     = x_r + 1'b1;
      glyph_nxt = {glyph_r[CELL_WIDTH-2:0], 1'b0};
    end

    ov_nxt = ov_r && !out_ch.ready;
    px_nxt = px_r;
    py_nxt = py_r;
    pc_nxt = pc_r;
    pl_nxt = pl_r;
    if (advance) begin
      ov_nxt = 1'b1;
      px_nxt = x_r;
      py_nxt = y_r;
      pc_nxt = (solid_r || glyph_r[CELL_WIDTH-1]) ? fg_r : bg_r;
      pl_nxt = last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    fg_r    <= fg_nxt;
    bg_r    <= bg_nxt;
    solid_r <= solid_nxt;
    glyph_r <= glyph_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    pc_r    <= pc_nxt;
    pl_r    <= pl_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.pixel_x      = px_r;
  assign out_ch.pixel_y      = py_r;
  assign out_ch.pixel_colour = pc_r;
  assign out_ch.last_pixel   = pl_r;

  `MTCR_ASSERT(a_k_in_cell, busy_r |-> k_r <= K_W'(CELL_WIDTH - 1), "pixel index past cell")
  `MTCR_ASSERT(a_line_wraps, (advance && last_k) |=> (k_r == '0 || !busy_r), "line did not end")
  `MTCR_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !busy_r && !ov_r, "back end not idle after reset")

endmodule

FILE: rtl/core/mono_text_cell_row_renderer.sv
// top level of the monochrome text cell row renderer
//
//   channel   direction  handshake          carries
//   in_ch     in         valid/ready        one cell line: column, row, line, attribute, glyph
//   out_ch    out        valid/ready        one pixel: x, y, colour, last flag
//   apb       in         psel/penable/pready colour registers at 0x0, 0x4, 0x8
//
// each item gives one pixel per cycle from the back end pixel counter while out_ch is not stalled
// items follow each other with no gap; a two-entry queue lets the front keep accepting
// a stalled output holds the pixel register and the back end waits
// synchronous active-low reset empties the queue and loads the default colours
module mono_text_cell_row_renderer (
  input  logic                            clk,
  input  logic                            rst_n,
  mtcr_in_if.sink                         in_ch,
  mtcr_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mtcr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mtcr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mtcr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mtcr_pkg::*;

  colour_set_t colours;
  q_stat_t     q_stat;
  q_entry_t    wr_entry;
  q_entry_t    rd_entry;
  logic        push;
  logic        pop;

  mtcr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .colours (colours)
  );

  mtcr_front u_front (
    .in_ch   (in_ch),
    .colours (colours),
    .q_stat  (q_stat),
    .push    (push),
    .entry   (wr_entry)
  );

  mtcr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .q_stat   (q_stat)
  );

  mtcr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_entry (rd_entry),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
